// ===== hdl/pfsm_pkg.sv =====
`timescale 1ns / 1ps

package pfsm_pkg;

   localparam int STATE_W        = 3;
   localparam int MASK_OUT_W     = 8;
   localparam int PC_W           = 3;
   localparam int NUM_STATES_DEF = 8;

   localparam logic [2:0] MODE_STEP    = 3'd0;
   localparam logic [2:0] MODE_CHANGE  = 3'd1;
   localparam logic [2:0] MODE_READ    = 3'd2;
   localparam logic [2:0] MODE_GARBAGE = 3'd3;
   localparam logic [2:0] MODE_DEL_ONE = 3'd4;
   localparam logic [2:0] MODE_DEL_ALL = 3'd5;

   typedef enum logic [2:0] {
      OP_LATCH,
      OP_STEP,
      OP_CHANGE,
      OP_READ,
      OP_INIT,
      OP_GROW,
      OP_FINISH,
      OP_RESPOND
   } uop_type;

   typedef enum logic [1:0] {
      JMP_GOTO,
      JMP_DISPATCH,
      JMP_LOOP,
      JMP_WAIT_RSP
   } jump_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      uop_type  op;
      jump_type jump;
      pc_type   target;
   } uword_type;

   localparam pc_type PC_WAIT    = 3'd0;
   localparam pc_type PC_STEP    = 3'd1;
   localparam pc_type PC_CHANGE  = 3'd2;
   localparam pc_type PC_READ    = 3'd3;
   localparam pc_type PC_INIT    = 3'd4;
   localparam pc_type PC_GROW    = 3'd5;
   localparam pc_type PC_FINISH  = 3'd6;
   localparam pc_type PC_RESPOND = 3'd7;

   localparam logic [STATE_W-1:0] INIT_ROWS [8][2] = '{
      '{3'd5, 3'd2}, '{3'd7, 3'd3}, '{3'd1, 3'd5}, '{3'd0, 3'd3},
      '{3'd2, 3'd7}, '{3'd4, 3'd6}, '{3'd3, 3'd4}, '{3'd6, 3'd1}
   };

   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      unique case (pc)
         PC_WAIT:    w = '{op: OP_LATCH,   jump: JMP_DISPATCH, target: PC_WAIT};
         PC_STEP:    w = '{op: OP_STEP,    jump: JMP_GOTO,     target: PC_RESPOND};
         PC_CHANGE:  w = '{op: OP_CHANGE,  jump: JMP_GOTO,     target: PC_RESPOND};
         PC_READ:    w = '{op: OP_READ,    jump: JMP_GOTO,     target: PC_RESPOND};
         PC_INIT:    w = '{op: OP_INIT,    jump: JMP_GOTO,     target: PC_GROW};
         PC_GROW:    w = '{op: OP_GROW,    jump: JMP_LOOP,     target: PC_FINISH};
         PC_FINISH:  w = '{op: OP_FINISH,  jump: JMP_GOTO,     target: PC_RESPOND};
         PC_RESPOND: w = '{op: OP_RESPOND, jump: JMP_WAIT_RSP, target: PC_WAIT};
      endcase
      return w;
   endfunction

   function automatic pc_type dispatch(input logic [2:0] mode);
      pc_type pc;
      unique case (mode)
         MODE_STEP:    pc = PC_STEP;
         MODE_CHANGE:  pc = PC_CHANGE;
         MODE_READ:    pc = PC_READ;
         MODE_GARBAGE,
         MODE_DEL_ONE,
         MODE_DEL_ALL: pc = PC_INIT;
         default:      pc = PC_RESPOND;
      endcase
      return pc;
   endfunction

   function automatic logic [STATE_W-1:0] init_entry(input logic [3:0] row, input logic b);
      logic [STATE_W-1:0] v;
      v = '0;
      if (!row[3]) begin
         v = INIT_ROWS[row[2:0]][b];
      end
      return v;
   endfunction

endpackage

// ===== hdl/programmable_fsm_with_reachability.sv =====
`timescale 1ns / 1ps
// Step, change and read pass from the latch step through their own microcode step to the
// respond step; unused modes go from the latch step straight to respond. Garbage query and
// both deletes run init, a closure loop that grows the reached set once a cycle, and finish,
// before respond. A new transaction is accepted only in the latch step, so req_stall holds
// requests until the last result is registered; a result waiting under rsp_stall holds respond.
// Reset: the table loads its fixed initial rows, the current state is 0, no state is deleted.

module programmable_fsm_with_reachability
   import pfsm_pkg::*;
#(
   parameter int NUM_STATES = NUM_STATES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_mode,
   input  logic                  req_input_bit,
   input  logic [STATE_W-1:0]    req_state_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATE_W-1:0]    rsp_current_state,
   output logic [MASK_OUT_W-1:0] rsp_garbage_mask,
   output logic [MASK_OUT_W-1:0] rsp_deleted_mask,
   output logic                  rsp_applied,
   output logic [STATE_W-1:0]    rsp_row_next_zero,
   output logic [STATE_W-1:0]    rsp_row_next_one,
   output logic                  rsp_row_deleted
);

   localparam int NS = NUM_STATES;
   localparam int MW = (NS > MASK_OUT_W) ? NS : MASK_OUT_W;
   localparam int CW = $clog2(NS);

   function automatic logic [NS-1:0] hot(input logic [STATE_W-1:0] v);
      logic [MW-1:0] w;
      w = MW'(1) << v;
      return w[NS-1:0];
   endfunction

   function automatic logic [MASK_OUT_W-1:0] out8(input logic [NS-1:0] m);
      logic [MW-1:0] w;
      w = MW'(m);
      return w[MASK_OUT_W-1:0];
   endfunction

   uword_type uw;

   pc_type                pc_ff, pc_in;
   logic [2:0]            mode_ff, mode_in;
   logic                  bit_ff, bit_in;
   logic [STATE_W-1:0]    idx_ff, idx_in;
   logic [STATE_W-1:0]    cur_ff, cur_in;
   logic [NS-1:0]         del_ff, del_in;
   logic [NS-1:0]         reach_ff, reach_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [NS-1:0]         garb_ff, garb_in;
   logic                  applied_ff, applied_in;
   logic [STATE_W-1:0]    r0_ff, r0_in;
   logic [STATE_W-1:0]    r1_ff, r1_in;
   logic                  rdel_ff, rdel_in;
   logic [STATE_W-1:0]    tbl_ff [NS][2];
   logic [STATE_W-1:0]    tbl_in [NS][2];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]    rsp_cur_ff, rsp_cur_in;
   logic [MASK_OUT_W-1:0] rsp_garb_ff, rsp_garb_in;
   logic [MASK_OUT_W-1:0] rsp_del_ff, rsp_del_in;
   logic                  rsp_applied_ff, rsp_applied_in;
   logic [STATE_W-1:0]    rsp_r0_ff, rsp_r0_in;
   logic [STATE_W-1:0]    rsp_r1_ff, rsp_r1_in;
   logic                  rsp_rdel_ff, rsp_rdel_in;

   logic                  req_accept;
   logic                  slot_free;
   logic                  loop_done;
   logic [NS-1:0]         cur_hot, idx_hot, addr_hot, grow, garbage;
   logic                  cur_ok, idx_ok, idx_del;
   logic [STATE_W-1:0]    rd0, rd1;

   assign uw         = ucode_rom(pc_ff);
   assign req_stall  = (uw.op != OP_LATCH);
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign loop_done  = (cnt_ff == CW'(NS - 1));

   assign cur_hot  = hot(cur_ff);
   assign idx_hot  = hot(idx_ff);
   assign cur_ok   = |cur_hot;
   assign idx_ok   = |idx_hot;
   assign idx_del  = |(idx_hot & del_ff);
   assign addr_hot = (uw.op == OP_READ) ? idx_hot : cur_hot;
   assign garbage  = ~reach_ff & ~del_ff;

   always_comb begin
      rd0  = '0;
      rd1  = '0;
      grow = reach_ff;
      for (int r = 0; r < NS; r++) begin
         if (addr_hot[r]) begin
            rd0 = rd0 | tbl_ff[r][0];
            rd1 = rd1 | tbl_ff[r][1];
         end
         if (reach_ff[r]) begin
            grow = grow | hot(tbl_ff[r][0]) | hot(tbl_ff[r][1]);
         end
      end
   end

   always_comb begin
      pc_in = pc_ff;
      unique case (uw.jump)
         JMP_GOTO: begin
            pc_in = uw.target;
         end
         JMP_DISPATCH: begin
            if (req_accept) begin
               pc_in = dispatch(req_mode);
            end
         end
         JMP_LOOP: begin
            if (loop_done) begin
               pc_in = uw.target;
            end
         end
         JMP_WAIT_RSP: begin
            if (slot_free) begin
               pc_in = uw.target;
            end
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      bit_in     = bit_ff;
      idx_in     = idx_ff;
      cur_in     = cur_ff;
      del_in     = del_ff;
      reach_in   = reach_ff;
      cnt_in     = cnt_ff;
      garb_in    = garb_ff;
      applied_in = applied_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      rdel_in    = rdel_ff;
      tbl_in     = tbl_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_cur_in     = rsp_cur_ff;
      rsp_garb_in    = rsp_garb_ff;
      rsp_del_in     = rsp_del_ff;
      rsp_applied_in = rsp_applied_ff;
      rsp_r0_in      = rsp_r0_ff;
      rsp_r1_in      = rsp_r1_ff;
      rsp_rdel_in    = rsp_rdel_ff;

      unique case (uw.op)
         OP_LATCH: begin
            if (req_accept) begin
               mode_in    = req_mode;
               bit_in     = req_input_bit;
               idx_in     = req_state_index;
               garb_in    = '0;
               applied_in = 1'b0;
               r0_in      = '0;
               r1_in      = '0;
               rdel_in    = 1'b0;
            end
         end
         OP_STEP: begin
            if (cur_ok) begin
               cur_in = bit_ff ? rd1 : rd0;
            end
         end
         OP_CHANGE: begin
            if (idx_ok && !idx_del && cur_ok) begin
               for (int r = 0; r < NS; r++) begin
                  if (cur_hot[r]) begin
                     tbl_in[r][bit_ff] = idx_ff;
                  end
               end
               applied_in = 1'b1;
            end
         end
         OP_READ: begin
            if (idx_ok) begin
               r0_in   = rd0;
               r1_in   = rd1;
               rdel_in = idx_del;
            end
         end
         OP_INIT: begin
            reach_in = cur_hot & ~del_ff;
            cnt_in   = '0;
         end
         OP_GROW: begin
            reach_in = grow & ~del_ff;
            cnt_in   = cnt_ff + CW'(1);
         end
         OP_FINISH: begin
            garb_in = garbage;
            if (mode_ff == MODE_DEL_ONE && |(garbage & idx_hot)) begin
               del_in     = del_ff | idx_hot;
               applied_in = 1'b1;
            end else if (mode_ff == MODE_DEL_ALL && |garbage) begin
               del_in     = del_ff | garbage;
               applied_in = 1'b1;
            end
         end
         OP_RESPOND: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_cur_in     = cur_ff;
               rsp_garb_in    = out8(garb_ff);
               rsp_del_in     = out8(del_ff);
               rsp_applied_in = applied_ff;
               rsp_r0_in      = r0_ff;
               rsp_r1_in      = r1_ff;
               rsp_rdel_in    = rdel_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_WAIT;
         cur_ff       <= '0;
         del_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < NS; r++) begin
            for (int b = 0; b < 2; b++) begin
               tbl_ff[r][b] <= (32'(init_entry(4'(r), 1'(b))) < NS) ?
                               init_entry(4'(r), 1'(b)) : '0;
            end
         end
      end else begin
         pc_ff        <= pc_in;
         cur_ff       <= cur_in;
         del_ff       <= del_in;
         rsp_valid_ff <= rsp_valid_in;
         tbl_ff       <= tbl_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      bit_ff         <= bit_in;
      idx_ff         <= idx_in;
      reach_ff       <= reach_in;
      cnt_ff         <= cnt_in;
      garb_ff        <= garb_in;
      applied_ff     <= applied_in;
      r0_ff          <= r0_in;
      r1_ff          <= r1_in;
      rdel_ff        <= rdel_in;
      rsp_cur_ff     <= rsp_cur_in;
      rsp_garb_ff    <= rsp_garb_in;
      rsp_del_ff     <= rsp_del_in;
      rsp_applied_ff <= rsp_applied_in;
      rsp_r0_ff      <= rsp_r0_in;
      rsp_r1_ff      <= rsp_r1_in;
      rsp_rdel_ff    <= rsp_rdel_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_state = rsp_cur_ff;
   assign rsp_garbage_mask  = rsp_garb_ff;
   assign rsp_deleted_mask  = rsp_del_ff;
   assign rsp_applied       = rsp_applied_ff;
   assign rsp_row_next_zero = rsp_r0_ff;
   assign rsp_row_next_one  = rsp_r1_ff;
   assign rsp_row_deleted   = rsp_rdel_ff;

   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(uw.op == OP_RESPOND))
      else $error("A result appeared without a respond step.");

   a_deleted_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (($past(del_ff) & ~del_ff) == '0))
      else $error("A deleted state was restored.");

   a_cur_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(cur_ff) < NS)
      else $error("The current state left the range of states.");

   a_reach_undeleted: assert property (@(posedge clock) disable iff (reset)
      (uw.op == OP_GROW) |-> ((reach_ff & del_ff) == '0))
      else $error("The reached set contains a deleted state.");

endmodule

// ===== bench/tb_programmable_fsm_with_reachability.sv =====
`timescale 1ns / 1ps

module tb_programmable_fsm_with_reachability
   import pfsm_pkg::*;
;

   localparam int NSTATES = NUM_STATES_DEF;
   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_ITEMS = 200;
   localparam int IDLE_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   typedef struct packed {
      logic [2:0] cur;
      logic [7:0] garbage;
      logic [7:0] deleted;
      logic       applied;
      logic [2:0] next0;
      logic [2:0] next1;
      logic       row_dead;
   } rsp_fields_type;

   typedef struct packed {
      logic [2:0]     mode;
      logic           ibit;
      logic [2:0]     idx;
      logic           known;
      rsp_fields_type want;
   } vector_type;

   localparam rsp_fields_type BLANK_RSP = '0;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_mode = MODE_STEP;
   logic       req_input_bit = 1'b0;
   logic [2:0] req_state_index = 3'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_current_state;
   logic [7:0] rsp_garbage_mask;
   logic [7:0] rsp_deleted_mask;
   logic       rsp_applied;
   logic [2:0] rsp_row_next_zero;
   logic [2:0] rsp_row_next_one;
   logic       rsp_row_deleted;

   logic [2:0]     fsm_next [NSTATES][2];
   logic [2:0]     fsm_cur;
   logic [7:0]     fsm_dead;
   rsp_fields_type expected_rsp_q[$];
   rsp_fields_type want_rsp;
   logic           quiet = 1'b0;
   int             stall_left = 0;
   int             idle_cycles = 0;
   int             errors = 0;
   int             n_sent = 0;
   int             n_checked = 0;
   int             n_deletes = 0;
   int             n_garbage_hits = 0;

   vector_type directed_vecs [25] = '{
      '{MODE_READ, 1'b0, 3'd0, 1'b1, '{3'd0, 8'h00, 8'h00, 1'b0, 3'd5, 3'd2, 1'b0}},
      '{MODE_READ, 1'b0, 3'd7, 1'b1, '{3'd0, 8'h00, 8'h00, 1'b0, 3'd6, 3'd1, 1'b0}},
      '{MODE_SPARE_A, 1'b1, 3'd7, 1'b1, BLANK_RSP},
      '{MODE_SPARE_B, 1'b0, 3'd0, 1'b1, BLANK_RSP},
      '{MODE_GARBAGE, 1'b0, 3'd0, 1'b1, BLANK_RSP},
      '{MODE_DEL_ONE, 1'b0, 3'd3, 1'b1, BLANK_RSP},
      '{MODE_DEL_ALL, 1'b1, 3'd0, 1'b1, BLANK_RSP},
      '{MODE_STEP, 1'b0, 3'd0, 1'b1, '{3'd5, 8'h00, 8'h00, 1'b0, 3'd0, 3'd0, 1'b0}},
      '{MODE_STEP, 1'b1, 3'd0, 1'b1, '{3'd6, 8'h00, 8'h00, 1'b0, 3'd0, 3'd0, 1'b0}},
      '{MODE_STEP, 1'b1, 3'd7, 1'b0, BLANK_RSP},
      '{MODE_CHANGE, 1'b0, 3'd4, 1'b0, BLANK_RSP},
      '{MODE_CHANGE, 1'b1, 3'd4, 1'b0, BLANK_RSP},
      '{MODE_GARBAGE, 1'b1, 3'd5, 1'b0, BLANK_RSP},
      '{MODE_DEL_ONE, 1'b0, 3'd0, 1'b0, BLANK_RSP},
      '{MODE_DEL_ONE, 1'b1, 3'd0, 1'b0, BLANK_RSP},
      '{MODE_DEL_ONE, 1'b0, 3'd4, 1'b0, BLANK_RSP},
      '{MODE_CHANGE, 1'b0, 3'd0, 1'b0, BLANK_RSP},
      '{MODE_READ, 1'b1, 3'd0, 1'b0, BLANK_RSP},
      '{MODE_CHANGE, 1'b1, 3'd7, 1'b0, BLANK_RSP},
      '{MODE_DEL_ALL, 1'b0, 3'd7, 1'b0, BLANK_RSP},
      '{MODE_DEL_ALL, 1'b1, 3'd1, 1'b0, BLANK_RSP},
      '{MODE_STEP, 1'b1, 3'd2, 1'b0, BLANK_RSP},
      '{MODE_READ, 1'b0, 3'd2, 1'b0, BLANK_RSP},
      '{MODE_CHANGE, 1'b0, 3'd7, 1'b0, BLANK_RSP},
      '{MODE_STEP, 1'b0, 3'd6, 1'b0, BLANK_RSP}
   };

   programmable_fsm_with_reachability dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_input_bit     (req_input_bit),
      .req_state_index   (req_state_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_state (rsp_current_state),
      .rsp_garbage_mask  (rsp_garbage_mask),
      .rsp_deleted_mask  (rsp_deleted_mask),
      .rsp_applied       (rsp_applied),
      .rsp_row_next_zero (rsp_row_next_zero),
      .rsp_row_next_one  (rsp_row_next_one),
      .rsp_row_deleted   (rsp_row_deleted)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic load_reset_table();
      fsm_next = '{'{3'd5, 3'd2}, '{3'd7, 3'd3}, '{3'd1, 3'd5}, '{3'd0, 3'd3},
                   '{3'd2, 3'd7}, '{3'd4, 3'd6}, '{3'd3, 3'd4}, '{3'd6, 3'd1}};
      fsm_cur = '0;
      fsm_dead = '0;
   endtask

   // The closure never enters a deleted state, and grows once per pass.
   function automatic logic [7:0] reach_from_current();
      logic [7:0] reach;
      logic [7:0] grow;
      logic [2:0] t;
      reach = '0;
      if (!fsm_dead[fsm_cur]) begin
         reach[fsm_cur] = 1'b1;
      end
      for (int it = 0; it < NSTATES; it++) begin
         grow = reach;
         for (int s = 0; s < NSTATES; s++) begin
            if (reach[s]) begin
               for (int b = 0; b < 2; b++) begin
                  t = fsm_next[s][b];
                  if (!fsm_dead[t]) begin
                     grow[t] = 1'b1;
                  end
               end
            end
         end
         reach = grow;
      end
      return reach;
   endfunction

   function automatic logic [7:0] garbage_now();
      return ~reach_from_current() & ~fsm_dead;
   endfunction

   function automatic rsp_fields_type predict_fsm(input logic [2:0] mode, input logic ibit,
                                                  input logic [2:0] idx);
      rsp_fields_type r;
      r = '0;
      case (mode)
         MODE_STEP: begin
            fsm_cur = fsm_next[fsm_cur][ibit];
         end
         MODE_CHANGE: begin
            if (!fsm_dead[idx]) begin
               fsm_next[fsm_cur][ibit] = idx;
               r.applied = 1'b1;
            end
         end
         MODE_READ: begin
            r.next0 = fsm_next[idx][0];
            r.next1 = fsm_next[idx][1];
            r.row_dead = fsm_dead[idx];
         end
         MODE_GARBAGE: begin
            r.garbage = garbage_now();
         end
         MODE_DEL_ONE: begin
            r.garbage = garbage_now();
            if (r.garbage[idx]) begin
               fsm_dead[idx] = 1'b1;
               r.applied = 1'b1;
            end
         end
         MODE_DEL_ALL: begin
            r.garbage = garbage_now();
            if (r.garbage != '0) begin
               fsm_dead = fsm_dead | r.garbage;
               r.applied = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.cur = fsm_cur;
      r.deleted = fsm_dead;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      errors++;
      $display("mismatch %0d at %0t: %s got 0x%0h, expected 0x%0h",
               errors, $time, what, got, want);
   endtask

   task automatic send_item(input logic [2:0] mode, input logic ibit, input logic [2:0] idx,
                            input logic known, input rsp_fields_type typed);
      rsp_fields_type predicted;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_input_bit <= ibit;
      req_state_index <= idx;
      do @(posedge clock); while (req_stall);
      predicted = predict_fsm(mode, ibit, idx);
      if (predicted.applied && (mode == MODE_DEL_ONE || mode == MODE_DEL_ALL)) begin
         n_deletes++;
      end
      if (predicted.garbage != '0) begin
         n_garbage_hits++;
      end
      expected_rsp_q.push_back(known ? typed : predicted);
      n_sent++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= int'($urandom_range(0, 3));
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction, current_state",
                            8'(rsp_current_state), 8'h00);
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            n_checked++;
            if (rsp_current_state !== want_rsp.cur)
               report_mismatch("current_state", 8'(rsp_current_state), 8'(want_rsp.cur));
            if (rsp_garbage_mask !== want_rsp.garbage)
               report_mismatch("garbage_mask", rsp_garbage_mask, want_rsp.garbage);
            if (rsp_deleted_mask !== want_rsp.deleted)
               report_mismatch("deleted_mask", rsp_deleted_mask, want_rsp.deleted);
            if (rsp_applied !== want_rsp.applied)
               report_mismatch("applied", 8'(rsp_applied), 8'(want_rsp.applied));
            if (rsp_row_next_zero !== want_rsp.next0)
               report_mismatch("row_next_zero", 8'(rsp_row_next_zero), 8'(want_rsp.next0));
            if (rsp_row_next_one !== want_rsp.next1)
               report_mismatch("row_next_one", 8'(rsp_row_next_one), 8'(want_rsp.next1));
            if (rsp_row_deleted !== want_rsp.row_dead)
               report_mismatch("row_deleted", 8'(rsp_row_deleted), 8'(want_rsp.row_dead));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [2:0] mode;
      logic [2:0] idx;
      logic [7:0] found;
      int pick;
      load_reset_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vecs[i]) begin
         send_item(directed_vecs[i].mode, directed_vecs[i].ibit, directed_vecs[i].idx,
                   directed_vecs[i].known, directed_vecs[i].want);
      end

      // Deletions are permanent, so they are held back until the table has wandered.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet <= 1'b1;
         end
         pick = $urandom_range(0, 99);
         idx = 3'($urandom_range(0, 7));
         if (pick < 30) mode = MODE_STEP;
         else if (pick < 54) mode = MODE_CHANGE;
         else if (pick < 66) mode = MODE_READ;
         else if (pick < 76) mode = MODE_GARBAGE;
         else if (pick < 88) mode = MODE_DEL_ONE;
         else if (pick < 91) mode = MODE_DEL_ALL;
         else if (pick < 95) mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
         else mode = MODE_STEP;
         if (n < RANDOM_ITEMS / 2 && (mode == MODE_DEL_ONE || mode == MODE_DEL_ALL)) begin
            mode = MODE_GARBAGE;
         end
         if (mode == MODE_DEL_ONE) begin
            found = garbage_now();
            if (found != '0 && $urandom_range(0, 9) < 6) begin
               do idx = 3'($urandom_range(0, 7)); while (!found[idx]);
            end
         end
         send_item(mode, 1'($urandom_range(0, 1)), idx, 1'b0, BLANK_RSP);
      end
      req_valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions driven (%0d directed), %0d results checked",
               n_sent, $size(directed_vecs), n_checked);
      $display("%0d results reported unreachable states, %0d deletions took effect, %s %b",
               n_garbage_hits, n_deletes, "final deleted set", fsm_dead);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
